// ===== src/mtg_pkg.sv =====
// Shared types, constants and the tempering function of the MT19937 generator.
// Used by the request queue, the execution unit and the top level.
package mtg_pkg;

  // Table geometry and recurrence constants
  localparam int unsigned StateWordsDefault = 624;
  localparam int unsigned ShiftSpan         = 397;
  localparam int unsigned QueueDepth        = 2;

  localparam logic [31:0] InitMult    = 32'h6C07_8965;
  localparam logic [31:0] TwistXor    = 32'h9908_B0DF;
  localparam logic [31:0] TemperB     = 32'h9D2C_5680;
  localparam logic [31:0] TemperC     = 32'hEFC6_0000;
  localparam logic [31:0] HighBit     = 32'h8000_0000;
  localparam logic [31:0] LowBits     = 32'h7FFF_FFFF;
  localparam logic [31:0] DefaultSeed = 32'd5489;

  // Request codes
  typedef enum logic {
    CMD_NEXT   = 1'b0,
    CMD_RESEED = 1'b1
  } cmd_e;

  // One queued request
  typedef struct packed {
    cmd_e        command;
    logic [31:0] seed_value;
  } item_t;

  // Head of the request queue as seen by the execution unit
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Status returned by the execution unit
  typedef struct packed {
    logic pop;
    logic init;
  } back_status_t;

  // Standard MT19937 output tempering
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== src/mtg_front.sv =====
// Front part of the generator: takes requests and holds them in a short queue.
// Depends on mtg_pkg for the request type and the queue depth.
module mtg_front
  import mtg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  item_t        item_i,
  input  logic         pop_i,
  output logic         full_o,
  output queue_head_t  head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t               entry_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = entry_q[rd_ptr_q];

  // Fill count stays within the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("request queue count out of range");

  // A request pushed into an empty queue shows at the head next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && count_q == '0) |=> head_o.valid)
    else $error("pushed request not visible at head");

  // An empty queue has equal read and write pointers
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

endmodule

// ===== src/mtg_back.sv =====
// Back part of the generator: state table memory, seeding, twist and tempering.
// Depends on mtg_pkg for constants, types and the tempering function.
module mtg_back
  import mtg_pkg::*;
#(
  parameter int unsigned STATE_WORDS = StateWordsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  queue_head_t   head_i,
  output back_status_t  status_o,
  output logic          result_valid_o,
  output logic [31:0]   random_word_o
);

  localparam int unsigned AddrW = $clog2(STATE_WORDS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(STATE_WORDS - 1);
  localparam logic [AddrW-1:0] FarStart = AddrW'(ShiftSpan);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SEED0    = 8'b0000_0010,
    ST_SEED_MUL = 8'b0000_0100,
    ST_SEED_WR  = 8'b0000_1000,
    ST_TW_PRE   = 8'b0001_0000,
    ST_TW_RD    = 8'b0010_0000,
    ST_TW_WR    = 8'b0100_0000,
    ST_NX_RD    = 8'b1000_0000
  } back_state_e;

  // State table memory
  logic [31:0] mem_q [STATE_WORDS];

  back_state_e       state_q, state_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0]  far_q, far_d;
  logic [AddrW-1:0]  pos_q, pos_d;
  logic              init_q, init_d;
  logic              out_phase_q, out_phase_d;
  logic              valid_q, valid_d;
  logic [31:0]       seed_q, seed_d;
  logic [31:0]       prev_q, prev_d;
  logic [31:0]       prod_q, prod_d;
  logic [31:0]       cur_q, cur_d;
  logic [31:0]       word_q, word_d;
  logic [31:0]       rd_a_q, rd_b_q;

  logic              we;
  logic [AddrW-1:0]  wa;
  logic [31:0]       wd;
  logic              re_a, re_b;
  logic [AddrW-1:0]  ra_a, ra_b;
  logic              pop;
  logic [AddrW-1:0]  idx_next;
  logic [31:0]       mix;
  logic [31:0]       twist_y;
  logic [31:0]       twist_w;
  logic [31:0]       seed_w;

  assign idx_next = (idx_q == LastAddr) ? '0 : idx_q + 1'b1;
  assign mix      = prev_q ^ (prev_q >> 30);
  assign twist_y  = (cur_q & HighBit) | (rd_a_q & LowBits);
  assign twist_w  = rd_b_q ^ (twist_y >> 1) ^ (twist_y[0] ? TwistXor : 32'h0);
  assign seed_w   = prod_q + {{(32 - AddrW){1'b0}}, idx_q};

  // Sequence seeding, twist and word read
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    far_d       = far_q;
    pos_d       = pos_q;
    init_d      = init_q;
    out_phase_d = 1'b0;
    valid_d     = 1'b0;
    seed_d      = seed_q;
    prev_d      = prev_q;
    prod_d      = prod_q;
    cur_d       = cur_q;
    word_d      = word_q;
    we          = 1'b0;
    wa          = idx_q;
    wd          = seed_w;
    re_a        = 1'b0;
    re_b        = 1'b0;
    ra_a        = idx_q;
    ra_b        = far_q;
    pop         = 1'b0;

    // Deliver the word read in the previous cycle
    if (out_phase_q) begin
      valid_d = 1'b1;
      word_d  = temper(rd_a_q);
      pos_d   = (pos_q == LastAddr) ? '0 : pos_q + 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid && !out_phase_q) begin
          pop = 1'b1;
          if (head_i.item.command == CMD_RESEED) begin
            seed_d  = head_i.item.seed_value;
            state_d = ST_SEED0;
          end else if (pos_q == '0) begin
            re_a    = 1'b1;
            ra_a    = '0;
            idx_d   = '0;
            far_d   = FarStart;
            state_d = ST_TW_PRE;
          end else begin
            state_d = ST_NX_RD;
          end
        end
      end
      ST_SEED0: begin
        we      = 1'b1;
        wa      = '0;
        wd      = seed_q;
        prev_d  = seed_q;
        idx_d   = AddrW'(1);
        pos_d   = '0;
        state_d = ST_SEED_MUL;
      end
      ST_SEED_MUL: begin
        prod_d  = InitMult * mix;
        state_d = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        we     = 1'b1;
        wa     = idx_q;
        wd     = seed_w;
        prev_d = seed_w;
        if (idx_q == LastAddr) begin
          init_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_next;
          state_d = ST_SEED_MUL;
        end
      end
      ST_TW_PRE: begin
        state_d = ST_TW_RD;
      end
      ST_TW_RD: begin
        cur_d   = rd_a_q;
        re_a    = 1'b1;
        ra_a    = idx_next;
        re_b    = 1'b1;
        ra_b    = far_q;
        state_d = ST_TW_WR;
      end
      ST_TW_WR: begin
        we = 1'b1;
        wa = idx_q;
        wd = twist_w;
        if (idx_q == LastAddr) begin
          state_d = ST_NX_RD;
        end else begin
          idx_d   = idx_next;
          far_d   = (far_q == LastAddr) ? '0 : far_q + 1'b1;
          state_d = ST_TW_RD;
        end
      end
      ST_NX_RD: begin
        re_a        = 1'b1;
        ra_a        = pos_q;
        out_phase_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the default seeding pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED0;
      pos_q       <= '0;
      init_q      <= 1'b1;
      out_phase_q <= 1'b0;
      valid_q     <= 1'b0;
      seed_q      <= DefaultSeed;
      idx_q       <= '0;
      far_q       <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      init_q      <= init_d;
      out_phase_q <= out_phase_d;
      valid_q     <= valid_d;
      seed_q      <= seed_d;
      idx_q       <= idx_d;
      far_q       <= far_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    prod_q <= prod_d;
    cur_q  <= cur_d;
    word_q <= word_d;
  end

  // Memory write port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
  end

  // Memory read ports, registered
  always_ff @(posedge clk_i) begin
    if (re_a) begin
      rd_a_q <= mem_q[ra_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_b) begin
      rd_b_q <= mem_q[ra_b];
    end
  end

  assign status_o.pop  = pop;
  assign status_o.init = init_q;
  assign result_valid_o = valid_q;
  assign random_word_o  = word_q;

  // A result strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe held for more than one cycle");

  // Table writes happen only while seeding or twisting
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_SEED0 || state_q == ST_SEED_WR || state_q == ST_TW_WR))
    else $error("table written outside seeding or twist");

  // Read position stays inside the table
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastAddr)
    else $error("read position out of range");

  // A strobe follows each word read
  a_read_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NX_RD) |=> valid_d)
    else $error("word read without result");

  // No request is taken while the previous word is still being delivered
  a_no_pop_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_phase_q |-> !pop)
    else $error("request popped during result delivery");

endmodule

// ===== src/mersenne_twister_generator_top.sv =====
// Top level of the MT19937 generator: request queue in front of the execution unit.
// Depends on mtg_pkg, mtg_front and mtg_back.
//
// A request is taken when start_i is high and busy_o low; command_i 0 asks for
// the next word, 1 reseeds with seed_value_i and gives no result. Each word
// appears on random_word_o for one cycle with result_valid_o high; the receiver
// cannot stall it. A next request, once it leaves the two-entry queue, reads its
// word from the table and tempers it on delivery; every 624th word (the first
// after each seeding) is preceded by a twist of the whole table, each table
// word taking a read state and a write state through the two-read, one-write
// table memory. A reseed passes each table word through the seeding multiplier
// and a write state. After reset busy_o stays high while the table is seeded
// with the default seed 5489.
module mersenne_twister_generator_top
  import mtg_pkg::*;
#(
  parameter int unsigned STATE_WORDS = StateWordsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  logic         command_i,
  input  logic [31:0]  seed_value_i,
  output logic         result_valid_o,
  output logic [31:0]  random_word_o
);

  item_t         item;
  queue_head_t   head;
  back_status_t  status;
  logic          full;

  assign item.command    = cmd_e'(command_i);
  assign item.seed_value = seed_value_i;

  // Hold requests off while the queue is full or the default seeding runs
  assign busy_o = full || status.init;

  mtg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (start_i && !busy_o),
    .item_i (item),
    .pop_i  (status.pop),
    .full_o (full),
    .head_o (head)
  );

  mtg_back #(
    .STATE_WORDS (STATE_WORDS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .random_word_o  (random_word_o)
  );

endmodule
